// ----- rtl/bkvat_pkg.sv -----
`timescale 1ns / 1ps

package bkvat_pkg;

   // Field widths of one request and one response.
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 16;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 4;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_SET    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   // One table entry as it sits in the memory.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } bkvat_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan;
      logic decide;
      logic move;
      logic load_rsp;
   } bkvat_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic scan_done;
      logic need_move;
      logic rsp_busy;
   } bkvat_status_type;

endpackage

// ----- rtl/bounded_key_value_attribute_table_top.sv -----
`timescale 1ns / 1ps

// Bounded key/value table with up to CAPACITY entries of 16-bit key and
// 32-bit raw value. Requests arrive as beats on the req_ stream: the action
// code travels in req_tuser, key and value in req_tdata. Each request makes
// exactly one response beat on the rsp_ stream with the found flag, the
// value read by a get, the write-accepted flag and the resulting entry count.
// A request runs through a sequential key search, one stored entry per
// cycle through the single read port of the entry memory, then a decide
// step that writes on a set, a move of the last entry on a remove, and the
// load of the output register, which waits while that register still holds
// a beat that is not taken. One request is handled at a time, so a new one
// is not taken before the last is through; req_tready is high between
// requests, from the cycle after the response is loaded.
// The response register holds its beat while rsp_tready is low; a new
// request is still taken, and its response waits until the register frees.
// Synchronous reset empties the table and drops any pending response; the
// entry memory itself is not cleared, since slots beyond the count are
// never read.
module bounded_key_value_attribute_table_top #(
   parameter int CAPACITY = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key [15:0], value_bits [47:16]
   input  logic [1:0]  req_tuser,   // action [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // found [0], read_bits [32:1],
                                    // write_accepted [33], entry_count [37:34]
);
   import bkvat_pkg::*;

   bkvat_cmd_type    cmd;
   bkvat_status_type status;

   logic               found;
   logic [VALUE_W-1:0] read_bits;
   logic               write_accepted;
   logic [COUNT_W-1:0] entry_count;

   bkvat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bkvat_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_tuser),
      .req_key            (req_tdata[15:0]),
      .req_value_bits     (req_tdata[47:16]),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_found          (found),
      .rsp_read_bits      (read_bits),
      .rsp_write_accepted (write_accepted),
      .rsp_entry_count    (entry_count)
   );

   // Pack the response fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {2'b00, entry_count, write_accepted, read_bits, found};

endmodule

// ----- rtl/bkvat_ctrl.sv -----
`timescale 1ns / 1ps

module bkvat_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  bkvat_pkg::bkvat_status_type status,
   output bkvat_pkg::bkvat_cmd_type    cmd
);
   import bkvat_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A new request is taken only between requests.
   assign req_tready = (state_ff == ST_IDLE);

   // Next state and the command for the current cycle.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.need_move ? ST_MOVE : ST_RESULT;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // Wait until the output register is free.
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/bkvat_dp.sv -----
`timescale 1ns / 1ps

module bkvat_dp #(
   parameter int CAPACITY = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bkvat_pkg::ACTION_W-1:0] req_action,
   input  logic [bkvat_pkg::KEY_W-1:0]    req_key,
   input  logic [bkvat_pkg::VALUE_W-1:0]  req_value_bits,
   input  bkvat_pkg::bkvat_cmd_type       cmd,
   output bkvat_pkg::bkvat_status_type    status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic [bkvat_pkg::VALUE_W-1:0]  rsp_read_bits,
   output logic                           rsp_write_accepted,
   output logic [bkvat_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import bkvat_pkg::*;

   // Count width holds CAPACITY itself; index width addresses the slots.
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // Entry memory: one write port, one registered read port.
   bkvat_entry_type mem [CAPACITY];
   bkvat_entry_type rd_data_ff;

   // Captured request.
   logic [ACTION_W-1:0] action_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;

   // Search and table state.
   logic [CW-1:0] count_ff,    count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [IW-1:0] cmp_idx_ff,  cmp_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic          hit_ff,      hit_in;
   logic [IW-1:0] slot_ff,     slot_in;
   logic          accepted_ff, accepted_in;

   // Output register.
   logic               rsp_valid_ff,    rsp_valid_in;
   logic               rsp_found_ff;
   logic [VALUE_W-1:0] rsp_read_ff;
   logic               rsp_accepted_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic                 issue_valid;
   logic                 match;
   logic                 rd_en;
   logic [CW-1:0]        rd_addr;
   logic [CW-1:0]        last_idx;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   bkvat_entry_type      wr_data;
   logic [CW+COUNT_W-1:0] count_ext;

   // Compare the entry read in the previous cycle; issue the next read.
   assign issue_valid = (scan_idx_ff < count_ff);
   assign match       = cmp_valid_ff && (rd_data_ff.key == key_ff);
   assign last_idx    = count_ff - ONE_C;

   assign status.scan_done = match || (!cmp_valid_ff && !issue_valid);
   assign status.need_move = (action_ff == ACT_REMOVE) && hit_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // Read port control: search reads, or the last entry for a remove.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_idx_ff;
      if (cmd.scan) begin
         rd_en = issue_valid && !match;
      end else if (cmd.decide) begin
         rd_en   = status.need_move;
         rd_addr = last_idx;
      end
   end

   // Write port control and count update.
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = '{key: key_ff, value: value_ff};
      count_in    = count_ff;
      accepted_in = accepted_ff;
      if (cmd.capture) begin
         accepted_in = 1'b0;
      end
      if (cmd.decide && (action_ff == ACT_SET)) begin
         if (hit_ff) begin
            wr_en       = 1'b1;
            accepted_in = 1'b1;
         end else if (count_ff < CAP_C) begin
            wr_en       = 1'b1;
            wr_addr     = count_ff[IW-1:0];
            count_in    = count_ff + ONE_C;
            accepted_in = 1'b1;
         end
      end
      if (cmd.move) begin
         // Last entry moves into the freed slot; a self copy is harmless.
         wr_en    = 1'b1;
         wr_data  = rd_data_ff;
         count_in = last_idx;
      end
   end

   // Search sequencing.
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      if (cmd.capture) begin
         scan_idx_in  = '0;
         cmp_valid_in = 1'b0;
         hit_in       = 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_in = issue_valid && !match;
         cmp_idx_in   = scan_idx_ff[IW-1:0];
         if (issue_valid) begin
            scan_idx_in = scan_idx_ff + ONE_C;
         end
         if (status.scan_done) begin
            hit_in  = match;
            slot_in = cmp_idx_ff;
         end
      end
   end

   // The output register frees itself when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   // Memory ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[IW-1:0]];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         value_ff  <= req_value_bits;
      end
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      accepted_ff <= accepted_in;
      if (cmd.load_rsp) begin
         rsp_found_ff    <= hit_ff;
         rsp_read_ff     <= ((action_ff == ACT_GET) && hit_ff) ? rd_data_ff.value : '0;
         rsp_accepted_ff <= accepted_ff;
         rsp_count_ff    <= count_ext[COUNT_W-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_read_bits      = rsp_read_ff;
   assign rsp_write_accepted = rsp_accepted_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

// ----- test/bounded_key_value_attribute_table_top_test.sv -----
`timescale 1ns / 1ps

module bounded_key_value_attribute_table_top_test;
   import bkvat_pkg::*;

   localparam int TABLE_SLOTS = 15;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int POOL_SIZE   = 24;

   // The fourth action code is undefined and must leave the table alone.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // One response beat, split into its fields.
   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_bits;
      logic               write_accepted;
      logic [COUNT_W-1:0] entry_count;
   } lookup_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // key [15:0], value_bits [47:16]
   logic [1:0]  req_tuser;   // action [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // found [0], read_bits [32:1],
                             // write_accepted [33], entry_count [37:34]

   // Shadow copy of the table contents.
   logic [KEY_W-1:0]   shadow_keys [TABLE_SLOTS];
   logic [VALUE_W-1:0] shadow_values [TABLE_SLOTS];
   int                 shadow_count;

   lookup_result_type  pending_results [$];
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];

   int  mismatch_count;
   int  quiet_cycles;
   int  hold_cycles;
   bit  idling_enabled;
   int  set_weight;

   bounded_key_value_attribute_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one request to the shadow table and return the response it should produce.
   function automatic lookup_result_type table_apply(input logic [ACTION_W-1:0] action,
                                                     input logic [KEY_W-1:0]    key,
                                                     input logic [VALUE_W-1:0]  value);
      lookup_result_type outcome;
      bit                hit;
      int                slot;
      outcome = '0;
      hit     = 1'b0;
      slot    = 0;
      for (int i = 0; i < shadow_count; i++) begin
         if (!hit && shadow_keys[i] == key) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      case (action)
         ACT_SET: begin
            if (hit) begin
               shadow_values[slot]    = value;
               outcome.write_accepted = 1'b1;
            end else if (shadow_count < TABLE_SLOTS) begin
               shadow_keys[shadow_count]   = key;
               shadow_values[shadow_count] = value;
               shadow_count++;
               outcome.write_accepted = 1'b1;
            end
         end
         ACT_GET: begin
            if (hit) begin
               outcome.read_bits = shadow_values[slot];
            end
         end
         ACT_REMOVE: begin
            // The last entry fills the hole left by the removed one.
            if (hit) begin
               shadow_keys[slot]   = shadow_keys[shadow_count-1];
               shadow_values[slot] = shadow_values[shadow_count-1];
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      outcome.found       = hit;
      outcome.entry_count = shadow_count[COUNT_W-1:0];
      return outcome;
   endfunction

   // Offer one request beat, wait for it to be taken, then record its expected response.
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [KEY_W-1:0]    key,
                               input logic [VALUE_W-1:0]  value);
      while (idling_enabled && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= action;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_results.push_back(table_apply(action, key, value));
   endtask

   // Mostly keys from a small pool so that hits, full tables and removals are common.
   task automatic send_random_request();
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      int                  pick;
      pick = $urandom_range(99);
      if (pick < set_weight) begin
         action = ACT_SET;
      end else if (pick < set_weight + (95 - set_weight) / 2) begin
         action = ACT_GET;
      end else if (pick < 95) begin
         action = ACT_REMOVE;
      end else begin
         action = ACT_UNUSED;
      end
      if ($urandom_range(9) == 0) begin
         key = KEY_W'($urandom);
      end else begin
         key = key_pool[$urandom_range(POOL_SIZE-1)];
      end
      send_request(action, key, $urandom);
   endtask

   task automatic release_request_bus();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      while (pending_results.size() > 0) begin
         @(posedge clock);
      end
   endtask

   // Lookups, removals and the undefined action on an empty table all miss.
   task automatic test_empty_table();
      send_request(ACT_GET, 16'h0000, 32'hDEAD_BEEF);
      send_request(ACT_REMOVE, 16'hFFFF, 32'h0000_0000);
      send_request(ACT_UNUSED, 16'h1234, 32'hFFFF_FFFF);
   endtask

   // Fill every slot, then try one more new key, which must be dropped.
   task automatic test_fill_and_overflow();
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         key   = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                 KEY_W'(16'h1000 + i * 16'h0111);
         value = (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
         send_request(ACT_SET, key, value);
      end
      send_request(ACT_SET, 16'h5A5A, 32'h1234_5678);
   endtask

   // An existing key can still be overwritten while the table is full.
   task automatic test_update_and_get();
      send_request(ACT_SET, 16'hFFFF, 32'h8000_0001);
      send_request(ACT_GET, 16'hFFFF, 32'h0000_0000);
   endtask

   // Remove from the first slot, which moves the last entry, then remove the last entry.
   task automatic test_remove_cases();
      send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);
      send_request(ACT_REMOVE, 16'h1DDD, 32'h0000_0000);
      send_request(ACT_GET, 16'h1EEE, 32'h0000_0000);
   endtask

   // The undefined action on a present key reports the hit and changes nothing.
   task automatic test_unused_action();
      send_request(ACT_UNUSED, 16'h1EEE, 32'hFFFF_FFFF);
      send_request(ACT_GET, 16'h1EEE, 32'h0000_0000);
   endtask

   // Random traffic in segments of varying set bias, one segment without any idling.
   task automatic test_random_traffic(input int item_total);
      int quiet_segment;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = KEY_W'($urandom);
      end
      quiet_segment = $urandom_range(item_total / 100 - 1);
      for (int i = 0; i < item_total; i++) begin
         if (i % 100 == 0) begin
            set_weight     = $urandom_range(20, 60);
            idling_enabled = (i / 100 != quiet_segment);
         end
         send_random_request();
      end
      idling_enabled = 1'b1;
   endtask

   // The receiver stops for a long while so that the block backs up into the request side.
   task automatic test_receiver_holdoff();
      hold_cycles = 300;
      repeat (30) send_random_request();
      release_request_bus();
      wait_until_drained();
   endtask

   // The sender stops until every response is back, then resumes.
   task automatic test_pause_and_resume();
      repeat (10) send_random_request();
      release_request_bus();
      wait_until_drained();
      repeat (10) send_random_request();
   endtask

   // Response side: random stalls, plus the long hold-off when one is requested.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= !(idling_enabled && $urandom_range(99) < 7);
         end
      end
   end

   // Compare every response beat with the oldest outstanding prediction.
   always @(posedge clock) begin
      lookup_result_type seen;
      lookup_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.found          = rsp_tdata[0];
         seen.read_bits      = rsp_tdata[32:1];
         seen.write_accepted = rsp_tdata[33];
         seen.entry_count    = rsp_tdata[37:34];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("Unexpected response beat at %0t: %h", $realtime, rsp_tdata);
            end
         end else begin
            wanted = pending_results.pop_front();
            if (seen.found !== wanted.found || seen.read_bits !== wanted.read_bits ||
                seen.write_accepted !== wanted.write_accepted ||
                seen.entry_count !== wanted.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Mismatch at %0t: found %b/%b read %h/%h accepted %b/%b count %0d/%0d",
                           $realtime, wanted.found, seen.found, wanted.read_bits,
                           seen.read_bits, wanted.write_accepted, seen.write_accepted,
                           wanted.entry_count, seen.entry_count);
               end
            end
         end
      end
   end

   // Give up when no beat has moved on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      mismatch_count = 0;
      quiet_cycles   = 0;
      hold_cycles    = 0;
      idling_enabled = 1'b1;
      set_weight     = 40;
      shadow_count   = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_SET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_and_overflow();
      test_update_and_get();
      test_remove_cases();
      test_unused_action();
      test_random_traffic(600);
      test_receiver_holdoff();
      test_pause_and_resume();

      release_request_bus();
      wait_until_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
